### rtl/core/sscl_pkg.sv
`default_nettype none
package sscl_pkg;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [16:0] TICK_MAX = 17'h1FFFF;

	// input item kinds
	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_RX   = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// command opcodes
	localparam logic [2:0] OP_ENABLE = 3'd0;
	localparam logic [2:0] OP_SPEED  = 3'd1;
	localparam logic [2:0] OP_STOP   = 3'd2;
	localparam logic [2:0] OP_RUN    = 3'd3;
	localparam logic [2:0] OP_RDERR  = 3'd4;

	// frame function codes
	localparam logic [7:0] CODE_ENABLE = 8'hF3;
	localparam logic [7:0] CODE_SPEED  = 8'hF6;
	localparam logic [7:0] CODE_STOP   = 8'hF7;
	localparam logic [7:0] CODE_RUN    = 8'hFD;
	localparam logic [7:0] CODE_RDERR  = 8'h39;

	// completion outcomes
	localparam logic [1:0] OUT_OK      = 2'd0;
	localparam logic [1:0] OUT_FAIL    = 2'd1;
	localparam logic [1:0] OUT_CSUM    = 2'd2;
	localparam logic [1:0] OUT_TIMEOUT = 2'd3;

	// output kinds
	localparam logic OK_TX   = 1'b0;
	localparam logic OK_CMPL = 1'b1;

	// config register indexes
	localparam logic CFG_ADDR    = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	// one job handed from front to back: a frame to send or a completion
	typedef struct packed {
		logic        is_cmpl;
		logic [2:0]  op;
		logic        en;
		logic [7:0]  val;
		logic [31:0] pulses;
		logic [7:0]  addr;
		logic [1:0]  outcome;
		logic [7:0]  status;
		logic [15:0] err;
	} job_t;

	// index of the checksum byte, equal to the count of data bytes
	function automatic logic [2:0] frame_len(input logic [2:0] op);
		logic [2:0] n;
		case (op)
			OP_ENABLE: n = 3'd3;
			OP_SPEED:  n = 3'd3;
			OP_STOP:   n = 3'd2;
			OP_RUN:    n = 3'd7;
			default:   n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] op_code(input logic [2:0] op);
		logic [7:0] c;
		case (op)
			OP_ENABLE: c = CODE_ENABLE;
			OP_SPEED:  c = CODE_SPEED;
			OP_STOP:   c = CODE_STOP;
			OP_RUN:    c = CODE_RUN;
			default:   c = CODE_RDERR;
		endcase
		return c;
	endfunction

	// data byte at position idx of a frame
	function automatic logic [7:0] frame_byte(input job_t j, input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = j.addr;
			3'd1: b = op_code(j.op);
			3'd2: b = (j.op == OP_ENABLE) ? {7'd0, j.en} : j.val;
			3'd3: b = j.pulses[31:24];
			3'd4: b = j.pulses[23:16];
			3'd5: b = j.pulses[15:8];
			3'd6: b = j.pulses[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### rtl/core/sscl_queue.sv
`default_nettype none
module sscl_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sscl_pkg::job_t      push_job,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output sscl_pkg::job_t      head
);
	import sscl_pkg::*;

	job_t           slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_q];

	// storage slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue fill count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not raise fill count");

endmodule
`default_nettype wire

### rtl/core/sscl_front.sv
`default_nettype none
module sscl_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire  [15:0]         cfg_wdata,
	input  wire                 accept,
	input  wire  [1:0]          item_kind,
	input  wire  [2:0]          opcode,
	input  wire                 enable_on,
	input  wire                 direction,
	input  wire  [6:0]          speed,
	input  wire  [31:0]         pulses,
	input  wire  [7:0]          rx_byte,
	output logic                push,
	output sscl_pkg::job_t      push_job
);
	import sscl_pkg::*;

	logic [7:0]  addr_q;
	logic [15:0] timeout_q;
	logic        waiting_q;
	logic [2:0]  pend_q;
	logic [1:0]  bidx_q;
	logic [7:0]  rsum_q;
	logic [7:0]  resp0_q;
	logic [7:0]  resp1_q;
	logic [16:0] ticks_q;

	logic [16:0] ticks_nx;
	logic        is_cmd;
	logic        is_tick;
	logic        is_rx;
	logic        timed_out;
	logic        rx_start;
	logic        rx_final;
	logic [7:0]  rx_sum;
	logic        st_ok;

	assign is_cmd    = accept && (item_kind == KIND_CMD) && !waiting_q && (opcode <= OP_RDERR);
	assign is_tick   = accept && (item_kind == KIND_TICK) && waiting_q;
	assign is_rx     = accept && (item_kind == KIND_RX) && waiting_q;
	assign ticks_nx  = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 1'b1;
	assign timed_out = is_tick && (ticks_nx > {1'b0, timeout_q});
	assign rx_start  = is_rx && (bidx_q == 2'd0);
	assign rx_final  = is_rx && (bidx_q != 2'd0) && (bidx_q != 2'd1)
		&& !((bidx_q == 2'd2) && (pend_q == OP_RDERR));
	assign rx_sum    = rsum_q + rx_byte;
	assign st_ok     = (pend_q == OP_RUN) ? (resp0_q != 8'd0) : (resp0_q == 8'd1);

	// job built from the accepted item
	always_comb begin
		push_job         = '0;
		push_job.op      = opcode;
		push_job.en      = enable_on;
		push_job.val     = {direction, speed};
		push_job.pulses  = pulses;
		push_job.addr    = addr_q;
		push             = is_cmd || timed_out || rx_final;
		if (!is_cmd) begin
			push_job.is_cmpl = 1'b1;
			push_job.pulses  = '0;
			if (timed_out) begin
				push_job.outcome = OUT_TIMEOUT;
			end else if (rx_byte != rsum_q) begin
				push_job.outcome = OUT_CSUM;
			end else if (pend_q == OP_RDERR) begin
				push_job.outcome = OUT_OK;
				push_job.err     = {resp0_q, resp1_q};
			end else begin
				push_job.outcome = st_ok ? OUT_OK : OUT_FAIL;
			end
			if (!timed_out && (pend_q != OP_RDERR)) begin
				push_job.status = resp0_q;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= 8'd224;
			timeout_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ADDR:    addr_q    <= cfg_wdata[7:0];
				CFG_TIMEOUT: timeout_q <= cfg_wdata;
				default:     addr_q    <= addr_q;
			endcase
		end
	end

	// response store, undefined until written
	always_ff @(posedge clk) begin
		if (is_rx && (bidx_q == 2'd1)) begin
			resp0_q <= rx_byte;
		end
		if (is_rx && (bidx_q == 2'd2) && (pend_q == OP_RDERR)) begin
			resp1_q <= rx_byte;
		end
	end

	// link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			pend_q    <= '0;
			bidx_q    <= '0;
			rsum_q    <= '0;
			ticks_q   <= '0;
		end else if (is_cmd) begin
			waiting_q <= 1'b1;
			pend_q    <= opcode;
			bidx_q    <= '0;
			rsum_q    <= '0;
			ticks_q   <= '0;
		end else if (is_tick) begin
			ticks_q <= ticks_nx;
			if (timed_out) begin
				waiting_q <= 1'b0;
				bidx_q    <= '0;
			end
		end else if (rx_final) begin
			waiting_q <= 1'b0;
			bidx_q    <= '0;
		end else if (rx_start) begin
			if (rx_byte == addr_q) begin
				rsum_q <= rx_byte;
				bidx_q <= 2'd1;
			end
		end else if (is_rx) begin
			rsum_q <= rx_sum;
			bidx_q <= bidx_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/sscl_back.sv
`default_nettype none
module sscl_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  sscl_pkg::job_t      head,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [39:0]         m_tdata,   // tx_byte, outcome, device_status, shaft_error, pad
	output logic                m_tlast,
	output logic                m_tuser    // out_kind
);
	import sscl_pkg::*;

	logic [2:0]  idx_q;
	logic [7:0]  sum_q;
	logic        vld_q;
	logic [39:0] data_q;
	logic        last_q;
	logic        kind_q;

	logic        load;
	logic        at_csum;
	logic [7:0]  cur_byte;

	assign load     = (!vld_q || m_tready) && head_valid;
	assign at_csum  = (idx_q == frame_len(head.op));
	assign cur_byte = frame_byte(head, idx_q);
	assign pop      = load && (head.is_cmpl || at_csum);

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = kind_q;

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (head.is_cmpl) begin
				data_q <= {6'd0, head.err, head.status, head.outcome, 8'd0};
				last_q <= 1'b0;
				kind_q <= OK_CMPL;
			end else begin
				data_q <= {32'd0, at_csum ? sum_q : cur_byte};
				last_q <= at_csum;
				kind_q <= OK_TX;
			end
		end
	end

	// byte position, checksum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
			sum_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
			if (load && !head.is_cmpl) begin
				if (at_csum) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
					sum_q <= sum_q + cur_byte;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/stepper_serial_command_link_core.sv
`default_nettype none
// channel   direction  tvalid/tready  tdata                               side bits
// s_*       in         item           opcode,enable_on,direction,speed,   tuser: item_kind
//                                     pulses,rx_byte
// m_*       out        item           tx_byte,outcome,device_status,      tuser: out_kind
//                                     shaft_error                         tlast: tx_last
// cfg_*     in         write enable   register index, 16-bit data         none
//
// the front takes one item per cycle while the two-entry job queue has room
// a frame of n bytes plus checksum leaves the back at one byte per cycle while m_tready is high,
// so a command's frame is 3 to 8 bytes long; a completion is a single output item
// reset clears link state, the queue and the output valid flag
// input stalls only when the queue is full; output stalls hold the back, which lets the queue fill
module stepper_serial_command_link_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [55:0] s_tdata,   // opcode, enable_on, direction, speed, pulses, rx_byte, pad
	input  wire  [1:0]  s_tuser,   // item_kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // tx_byte, outcome, device_status, shaft_error, pad
	output logic        m_tlast,
	output logic        m_tuser,   // out_kind
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_wdata
);
	import sscl_pkg::*;

	logic accept;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic not_empty;
	job_t head;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// front: classify items and track the response
	sscl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item_kind (s_tuser),
		.opcode    (s_tdata[2:0]),
		.enable_on (s_tdata[3]),
		.direction (s_tdata[4]),
		.speed     (s_tdata[11:5]),
		.pulses    (s_tdata[43:12]),
		.rx_byte   (s_tdata[51:44]),
		.push      (push),
		.push_job  (push_job)
	);

	// job queue
	sscl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: serialize frames and emit completions
	sscl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
`default_nettype wire
